[design/ntcb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ntcb_pkg
// Shared types and constants of the NTC beta-equation temperature converter.
// ----------------------------------------------------------------------------
package ntcb_pkg;

  // widest log2 operand (series / r25 resistance, divider legs)
  localparam int XW        = 20;
  // integer part of a log2 result (msb position of a 20-bit value)
  localparam int LOG_INT_W = 5;
  // Q30 mantissa in [1,2)
  localparam int MANT_W    = 31;

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [14:0] T25_CENTI_K  = 15'd29815;
  localparam logic [21:0] NUM_SCALE    = 22'd2981500;  // 100 * 29815 (298.15 K in 0.01 K)
  localparam logic [15:0] ZERO_C_CK    = 16'd27315;
  localparam logic [15:0] TEMP_MAX     = 16'd32767;
  localparam logic [15:0] TCK_MAX      = 16'd60082;    // 27315 + 32767

  // configuration register indexes
  localparam logic [1:0] REG_VREF   = 2'd0;
  localparam logic [1:0] REG_SERIES = 2'd1;
  localparam logic [1:0] REG_BETA   = 2'd2;
  localparam logic [1:0] REG_R25    = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RAIL = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

endpackage
`default_nettype wire

[design/ntcb_log2_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ntcb_log2_lane
// Pipelined fixed-point log2: normalize, then one mantissa squaring per stage.
// ----------------------------------------------------------------------------
module ntcb_log2_lane import ntcb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [XW-1:0]                 x_i,
  output logic      [LOG_INT_W+FRAC_BITS-1:0] log_o
);

  localparam int LW = LOG_INT_W + FRAC_BITS;

  logic [LOG_INT_W-1:0] msb;
  logic [MANT_W-1:0]    mant0;

  // msb position; zero input gives msb 0 and mantissa 0 (result unused)
  always_comb begin
    msb = '0;
    for (int b = 0; b < XW; b++) begin
      if (x_i[b]) msb = LOG_INT_W'(b);
    end
    mant0 = MANT_W'(x_i) << (LOG_INT_W'(30) - msb);
  end

  logic [MANT_W-1:0] m_q [0:FRAC_BITS];
  logic [LW-1:0]     r_q [0:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= mant0;
      r_q[0] <= LW'(msb) << FRAC_BITS;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    logic [MANT_W-1:0]   m_d;
    logic [LW-1:0]       r_d;

    always_comb begin
      sq = (2*MANT_W)'(m_q[k-1]) * (2*MANT_W)'(m_q[k-1]);
      t  = sq[2*MANT_W-1:MANT_W-1];
      if (t[MANT_W]) begin
        m_d = t[MANT_W:1];
        r_d = r_q[k-1] | (LW'(1) << (FRAC_BITS - k));
      end else begin
        m_d = t[MANT_W-1:0];
        r_d = r_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k] <= m_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign log_o = r_q[FRAC_BITS];

endmodule
`default_nettype wire

[design/ntc_beta_temperature_converter.sv]
`default_nettype none
// Throughput: one beat per cycle; every stage moves on one shared enable,
//   which drops only while a result beat sits unaccepted at the output.
// Stages: log2 normalize and squaring stages plus a 16-stage restoring divider.
// Reset: pipeline empty, configuration registers at 3300 mV, 10 kohm, 3950 K,
//   10 kohm. No clearing pass.
// ----------------------------------------------------------------------------
// ntc_beta_temperature_converter
// ADC code of a thermistor divider to temperature in 0.01 C (beta equation).
// ----------------------------------------------------------------------------
module ntc_beta_temperature_converter import ntcb_pkg::*; #(
  parameter int ADC_FULL_SCALE = 4095,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i,
  // sample channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [11:0] adc_code_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      temp_centi_c_o,
  output logic [1:0]       status_o
);

  localparam int FSW  = $clog2(ADC_FULL_SCALE + 1);
  localparam int OW   = (FSW > 12) ? FSW : 12;      // code arithmetic width
  localparam int PW   = OW + 13;                     // code * vref
  localparam int LW   = LOG_INT_W + FRAC_BITS;       // log2 result
  localparam int MW   = LW + 1;                      // |L| magnitude
  localparam int DW   = FRAC_BITS + 24;              // signed denominator
  localparam int NUMW = FRAC_BITS + 36;              // numerator
  localparam int NW   = NUMW + 1;                    // numerator + d/2
  localparam int CW   = FRAC_BITS + 40;              // divider compare width
  localparam int QW   = 16;                          // quotient bits
  localparam int LAT_LOG = FRAC_BITS + 1;
  localparam int NST  = LAT_LOG + QW + 6;            // valid-bit stages

  // --------------------------------------------------------------------------
  // Configuration registers; the user must write them only while the pipeline
  // is empty (not enforced by the block), so every stage reads them directly.
  // --------------------------------------------------------------------------
  logic [12:0] vref_q;
  logic [19:0] series_q;
  logic [13:0] beta_q;
  logic [19:0] r25_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q   <= 13'd3300;
      series_q <= 20'd10000;
      beta_q   <= 14'd3950;
      r25_q    <= 20'd10000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VREF:   vref_q   <= cfg_data_i[12:0];
        REG_SERIES: series_q <= cfg_data_i;
        REG_BETA:   beta_q   <= cfg_data_i[13:0];
        REG_R25:    r25_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // One enable for the whole pipe: advance whenever the output slot is free
  // or being emptied this cycle. Valid bits shift with the data.
  // --------------------------------------------------------------------------
  logic           adv;
  logic [NST-1:0] v_q;

  assign adv        = !v_q[NST-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register, rail test, log operands
  // --------------------------------------------------------------------------
  logic [11:0] code_q;

  always_ff @(posedge clk_i) begin
    if (adv) code_q <= adc_code_i;
  end

  logic [OW-1:0] code_w, fs_w, rest_w;
  logic [PW-1:0] lo_prod, hi_prod;
  logic          rail;
  status_e       cls0;

  always_comb begin
    code_w  = OW'(code_q);
    fs_w    = OW'(ADC_FULL_SCALE);
    rest_w  = fs_w - code_w;
    lo_prod = PW'(code_w) * PW'(vref_q);
    hi_prod = PW'(rest_w) * PW'(vref_q);
    // within 1 mV of ground or of the reference, or at or past full scale
    rail    = (code_w >= fs_w) || (lo_prod <= PW'(fs_w)) || (hi_prod <= PW'(fs_w));
    if (rail) begin
      cls0 = ST_RAIL;
    end else if (series_q == '0 || r25_q == '0 || beta_q == '0) begin
      cls0 = ST_SAT;
    end else begin
      cls0 = ST_OK;
    end
  end

  // four log2 lanes: ln(R/r25) = ln2 * (lg series + lg c - lg (FS-c) - lg r25)
  logic [LW-1:0] lg_ser, lg_code, lg_rest, lg_r25;

  ntcb_log2_lane #(.FRAC_BITS(FRAC_BITS)) u_lg_ser (
    .clk_i, .en_i(adv), .x_i(series_q), .log_o(lg_ser)
  );
  ntcb_log2_lane #(.FRAC_BITS(FRAC_BITS)) u_lg_code (
    .clk_i, .en_i(adv), .x_i(XW'(code_w)), .log_o(lg_code)
  );
  ntcb_log2_lane #(.FRAC_BITS(FRAC_BITS)) u_lg_rest (
    .clk_i, .en_i(adv), .x_i(XW'(rest_w)), .log_o(lg_rest)
  );
  ntcb_log2_lane #(.FRAC_BITS(FRAC_BITS)) u_lg_r25 (
    .clk_i, .en_i(adv), .x_i(r25_q), .log_o(lg_r25)
  );

  // class code rides alongside the lanes
  status_e cls_q [1:LAT_LOG];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q[1] <= cls0;
      for (int k = 2; k <= LAT_LOG; k++) cls_q[k] <= cls_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // SUM stage: signed log difference as sign + magnitude
  // --------------------------------------------------------------------------
  logic [MW-1:0] pos_sum, neg_sum;
  logic [MW-1:0] mag_q;
  logic          neg_q;
  status_e       cls_sum_q;

  assign pos_sum = MW'(lg_ser) + MW'(lg_code);
  assign neg_sum = MW'(lg_rest) + MW'(lg_r25);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q     <= neg_sum > pos_sum;
      mag_q     <= (neg_sum > pos_sum) ? neg_sum - pos_sum : pos_sum - neg_sum;
      cls_sum_q <= cls_q[LAT_LOG];
    end
  end

  // --------------------------------------------------------------------------
  // LN stage: times ln2 (Q32), round half away from zero; numerator product
  // --------------------------------------------------------------------------
  logic [MW+32:0]     ln_prod;
  logic [MW-1:0]      ln_mag;
  logic [35:0]        num_base;
  logic signed [MW:0] lnr_q;
  logic [NUMW-1:0]    num_q;
  status_e            cls_ln_q;

  assign ln_prod  = (MW+33)'(mag_q) * (MW+33)'(LN2_Q32) + ((MW+33)'(1) << 31);
  assign ln_mag   = ln_prod[MW+31:32];
  assign num_base = 36'(beta_q) * 36'(NUM_SCALE);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lnr_q    <= neg_q ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
      num_q    <= NUMW'(num_base) << FRAC_BITS;
      cls_ln_q <= cls_sum_q;
    end
  end

  // --------------------------------------------------------------------------
  // DEN stage: den = (100*beta << F) + 29815 * ln r; must be positive
  // --------------------------------------------------------------------------
  logic [20:0]        beta100;
  logic signed [DW-1:0] den;
  logic [DW-2:0]      d_q;
  logic [NUMW-1:0]    num_d_q;
  status_e            cls_den_q;

  assign beta100 = 21'(beta_q) * 21'd100;
  assign den = $signed(DW'(beta100) << FRAC_BITS)
             + DW'(lnr_q) * $signed(DW'(T25_CENTI_K));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q     <= den[DW-2:0];
      num_d_q <= num_q;
      if (cls_ln_q == ST_OK && (den[DW-1] || den == '0)) begin
        cls_den_q <= ST_SAT;
      end else begin
        cls_den_q <= cls_ln_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // PRE stage: add d/2 for rounding, flag quotients that cannot fit 16 bits
  // --------------------------------------------------------------------------
  logic [NW-1:0] rnd_num;
  logic          quo_ovf;

  logic [NW-1:0] rem_q  [0:QW];
  logic [DW-2:0] dv_q   [0:QW];
  logic [QW-1:0] quo_q  [0:QW];
  status_e       cls_dv_q [0:QW];

  assign rnd_num = NW'(num_d_q) + NW'(d_q >> 1);
  assign quo_ovf = CW'(rnd_num) >= (CW'(d_q) << QW);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= rnd_num;
      dv_q[0]  <= d_q;
      quo_q[0] <= '0;
      if (cls_den_q == ST_OK && quo_ovf) begin
        cls_dv_q[0] <= ST_SAT;
      end else begin
        cls_dv_q[0] <= cls_den_q;
      end
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [CW-1:0] shd;
    logic          take;

    assign shd  = CW'(dv_q[j-1]) << (QW - j);
    assign take = CW'(rem_q[j-1]) >= shd;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[j]    <= take ? rem_q[j-1] - NW'(shd) : rem_q[j-1];
        quo_q[j]    <= quo_q[j-1] | (take ? (QW'(1) << (QW - j)) : '0);
        dv_q[j]     <= dv_q[j-1];
        cls_dv_q[j] <= cls_dv_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // OUT stage: kelvin to Celsius, final range check
  // --------------------------------------------------------------------------
  logic [15:0] temp_q;
  status_e     status_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (cls_dv_q[QW])
        ST_RAIL: begin
          temp_q   <= '0;
          status_q <= ST_RAIL;
        end
        ST_OK: begin
          if (quo_q[QW] > TCK_MAX) begin
            temp_q   <= TEMP_MAX;
            status_q <= ST_SAT;
          end else begin
            temp_q   <= quo_q[QW] - ZERO_C_CK;
            status_q <= ST_OK;
          end
        end
        default: begin
          temp_q   <= TEMP_MAX;
          status_q <= ST_SAT;
        end
      endcase
    end
  end

  assign out_valid_o    = v_q[NST-1];
  assign temp_centi_c_o = temp_q;
  assign status_o       = status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_RAIL |-> temp_centi_c_o == '0)
    else $error("rail fault beat with nonzero temperature");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SAT |-> temp_centi_c_o == TEMP_MAX)
    else $error("saturated beat not at full scale");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> $signed(temp_centi_c_o) >= -16'sd27315)
    else $error("valid beat below absolute zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_RAIL || status_o == ST_SAT)
    else $error("undefined status code on a result beat");

endmodule
`default_nettype wire

[tb/sv/ntc_beta_temperature_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_beta_temperature_converter_tb
// Self-checking bench for the thermistor beta-equation converter. A built-in
// fixed-point predictor computes the temperature and status of every accepted
// sample beat. A monitor compares each result beat, in order, with the oldest
// pending prediction. Both sides idle at random, and the settings are changed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_converter_tb;
  import ntcb_pkg::*;

  localparam int FS       = 4095;
  localparam int FRAC     = 16;
  localparam int LATENCY  = FRAC + 23;
  localparam int MAX_CYC  = 400000;

  typedef struct packed {
    logic [15:0] temp;
    status_e     status;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_VREF;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] adc_code_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] temp_centi_c_o;
  logic [1:0]  status_o;

  ntc_beta_temperature_converter dut (.*);

  // bench copy of the settings
  longint unsigned vref_mv, series_r, beta_k, r25_r;

  reading_t pending_readings[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  longint   cycle_count = 0;

  initial forever #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  // log2 in Q16: msb position plus sixteen squaring steps on a Q30 mantissa
  function automatic longint unsigned log2_fix(longint unsigned x);
    int unsigned     n;
    longint unsigned t, m, r;
    n = 0;
    t = x;
    while (t > 1 && n < 30) begin
      t >>= 1;
      n++;
    end
    m = x << (30 - n);
    r = longint'(n) << FRAC;
    for (int i = FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        r |= 64'd1 << i;
      end
    end
    return r;
  endfunction

  function automatic reading_t predict_temperature(logic [11:0] code);
    longint unsigned c, pos, neg, mag, lnmag, num, d, tck;
    longint          lnr, den;
    reading_t        rd;
    c = code;
    rd.temp = '0;
    rd.status = ST_OK;
    if (c >= FS || c * vref_mv <= FS || (FS - c) * vref_mv <= FS) begin
      rd.status = ST_RAIL;
    end else if (series_r == 0 || r25_r == 0 || beta_k == 0) begin
      rd.temp = TEMP_MAX;
      rd.status = ST_SAT;
    end else begin
      pos = log2_fix(series_r) + log2_fix(c);
      neg = log2_fix(FS - c) + log2_fix(r25_r);
      mag = (neg > pos) ? neg - pos : pos - neg;
      lnmag = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
      lnr = (neg > pos) ? -longint'(lnmag) : longint'(lnmag);
      den = longint'((100 * beta_k) << FRAC) + 29815 * lnr;
      if (den <= 0) begin
        rd.temp = TEMP_MAX;
        rd.status = ST_SAT;
      end else begin
        d = den;
        num = (100 * beta_k * 29815) << FRAC;
        tck = (num + d / 2) / d;
        if (tck > 60082) begin
          rd.temp = TEMP_MAX;
          rd.status = ST_SAT;
        end else begin
          rd.temp = 16'(tck - 27315);
        end
      end
    end
    return rd;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor: oldest prediction first
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_readings.pop_front();
        if (temp_centi_c_o !== want.temp)
          report_mismatch($sformatf("temp %0d, want %0d",
                                    $signed(temp_centi_c_o), $signed(want.temp)));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYC) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // one sample beat; valid stays up afterwards until the next gap or drain
  task automatic send_sample(logic [11:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    pending_readings.push_back(predict_temperature(code));
  endtask

  // drop valid, let every pending result arrive, then let the pipe settle
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // one register beat; valid stays up so back-to-back writes need no gap
  task automatic write_setting(logic [1:0] idx, logic [19:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_VREF:   vref_mv  = value & 20'h1FFF;
      REG_SERIES: series_r = value;
      REG_BETA:   beta_k   = value & 20'h3FFF;
      default:    r25_r    = value;
    endcase
  endtask

  task automatic write_all(logic [19:0] vr, logic [19:0] sr, logic [19:0] bk,
                           logic [19:0] rr);
    write_setting(REG_VREF, vr);
    write_setting(REG_SERIES, sr);
    write_setting(REG_BETA, bk);
    write_setting(REG_R25, rr);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly full-range codes, with rails and near-rail codes mixed in
  function automatic logic [11:0] pick_code();
    case ($urandom_range(9))
      0:       return 12'($urandom_range(0, 6));
      1:       return 12'($urandom_range(4089, 4095));
      default: return 12'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  // reset settings: rails, full-scale code, midpoint, bit extremes
  task automatic test_reset_settings();
    logic [11:0] codes[$] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4092, 12'd4093,
                             12'd4094, 12'd4095, 12'd2048, 12'd2047, 12'd1365,
                             12'd2730, 12'd100, 12'd4000};
    foreach (codes[i]) send_sample(codes[i]);
    drain_pipe();
  endtask

  // register extremes: zero resistors and beta, zero and max vref,
  // negative reciprocal and over-range results with tiny beta
  task automatic test_setting_extremes();
    logic [11:0] codes[$] = '{12'd1, 12'd5, 12'd300, 12'd2048, 12'd3900, 12'd4090};
    write_all(20'd0, 20'd10000, 20'd3950, 20'd10000);
    foreach (codes[i]) send_sample(codes[i]);
    drain_pipe();
    write_all(20'h1FFF, 20'd0, 20'd3950, 20'd10000);
    foreach (codes[i]) send_sample(codes[i]);
    drain_pipe();
    write_all(20'd1000, 20'd10000, 20'd0, 20'd0);
    foreach (codes[i]) send_sample(codes[i]);
    drain_pipe();
    write_all(20'd5500, 20'd1, 20'd1, 20'hFFFFF);
    foreach (codes[i]) send_sample(codes[i]);
    drain_pipe();
    write_all(20'd1000, 20'hFFFFF, 20'h3FFF, 20'd1);
    foreach (codes[i]) send_sample(codes[i]);
    drain_pipe();
  endtask

  task automatic test_random_phase(int s_idle, int r_idle, int n_items);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int blk = 0; blk < 5; blk++) begin
      if ($urandom_range(3) == 0)
        write_all(20'($urandom_range(0, 8191)), 20'($urandom_range(0, 20)),
                  20'($urandom_range(0, 16383)), 20'($urandom));
      else
        write_all(20'($urandom_range(1000, 5500)), 20'($urandom_range(1, 1000000)),
                  20'($urandom_range(1, 10000)), 20'($urandom_range(1, 1000000)));
      for (int i = 0; i < n_items / 5; i++) send_sample(pick_code());
      drain_pipe();
    end
  endtask

  initial begin
    vref_mv  = 3300;
    series_r = 10000;
    beta_k   = 3950;
    r25_r    = 10000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 13;
    recv_idle_pct = 76;
    test_reset_settings();
    test_setting_extremes();
    test_random_phase(13, 76, 550);
    test_random_phase(76, 13, 550);
    test_random_phase(0, 0, 550);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
